### sv/plkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plkc_pkg
// Shared types and constants of the piecewise-linear key compressor.
// ----------------------------------------------------------------------------
package plkc_pkg;

  localparam int KEY_W    = 32;
  localparam int SLOPE_W  = 48;
  localparam int NUM_W    = 33;
  localparam int DEN_W    = 5;
  localparam int EB_W     = 7;
  localparam int WIDTH_W  = 4;

  localparam logic [EB_W-1:0]    EB_RESET   = 7'd127;
  localparam logic [31:0]        SEG_COST   = 32'd104;
  localparam logic [SLOPE_W-1:0] SLOPE_ONES = {SLOPE_W{1'b1}};

  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // Register index decode: bit 2 of the byte address selects the register.
  localparam logic CFG_IDX_EB = 1'b0;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SLOPE_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               item_kind;
    logic [7:0]         packed_byte;
    logic [31:0]        segment_first_index;
    logic [SLOPE_W-1:0] segment_slope;
    logic [WIDTH_W-1:0] code_width;
    logic [31:0]        segment_first_byte;
    logic [31:0]        running_bits;
    logic               run_last;
  } out_t;

endpackage
`default_nettype wire

### sv/plkc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plkc_in_if
// Key request channel: valid/ready with key and end marker.
// ----------------------------------------------------------------------------
interface plkc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_value;
  logic        end_of_keys;

  modport source (output valid, output key_value, output end_of_keys, input ready);
  modport sink   (input valid, input key_value, input end_of_keys, output ready);
endinterface
`default_nettype wire

### sv/plkc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plkc_out_if
// Result request channel: valid/ready with header or packed byte fields.
// ----------------------------------------------------------------------------
interface plkc_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  packed_byte;
  logic [31:0] segment_first_index;
  logic [47:0] segment_slope;
  logic [3:0]  code_width;
  logic [31:0] segment_first_byte;
  logic [31:0] running_bits;
  logic        run_last;

  modport source (output valid, output item_kind, output packed_byte,
                  output segment_first_index, output segment_slope, output code_width,
                  output segment_first_byte, output running_bits, output run_last,
                  input ready);
  modport sink   (input valid, input item_kind, input packed_byte,
                  input segment_first_index, input segment_slope, input code_width,
                  input segment_first_byte, input running_bits, input run_last,
                  output ready);
endinterface
`default_nettype wire

### sv/plkc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plkc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/plkc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plkc_div
// Bit-serial restoring divider: saturate((num << FRAC_BITS) / den).
// ----------------------------------------------------------------------------
module plkc_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire plkc_pkg::div_req_t req,
  output      plkc_pkg::div_rsp_t rsp
);

  localparam int NW = plkc_pkg::NUM_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam int DW = plkc_pkg::DEN_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [63:0]   qx;

  always_comb begin
    rem_sh   = {rem_r[DW-1:0], dvd_r[NW-1]};
    ge       = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      dvd_nxt  = NW'(req.num) << FRAC_BITS;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_nxt = {quo_r[NW-2:0], ge};
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  always_comb begin
    qx       = 64'(quo_r);
    rsp.done = done_r;
    rsp.quo  = (qx[63:plkc_pkg::SLOPE_W] != '0) ? plkc_pkg::SLOPE_ONES
                                                : qx[plkc_pkg::SLOPE_W-1:0];
  end

endmodule
`default_nettype wire

### sv/piecewise_linear_key_compressor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_key_compressor_unit
// Shrinking-cone piecewise-linear compressor for a stream of 32-bit keys.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Carries
//  in_if     sink       valid/ready        key_value, end_of_keys
//  out_if    source     valid/ready        header or packed delta byte
//  cfg (APB) slave      psel/penable, rdy  error_bound at byte address 0
//
// A joining key takes up to three serial divisions: point slope, then upper and
// lower cone bound. A close walks the key RAM twice: RD1 and PR1 per key for the
// code width, then RD2, PR2 and EMIT per key plus an EMIT per packed byte, and
// the bytes go out one per cycle while out_if is ready. Reset is synchronous
// and active low; no clearing pass is needed. A stalled out_if holds the byte
// emitter; in_if is ready only while no request is in work.
// ----------------------------------------------------------------------------
module piecewise_linear_key_compressor_unit #(
  parameter int MAX_SEGMENT         = 32,
  parameter int SLOPE_FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  plkc_in_if.sink          in_if,
  plkc_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int AW      = $clog2(MAX_SEGMENT);
  localparam int CNT_W   = $clog2(MAX_SEGMENT + 1);
  localparam int SW      = plkc_pkg::SLOPE_W;
  localparam int PACC_W  = SW + AW;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV   = 4'd1;
  localparam logic [3:0] ST_JOIN  = 4'd2;
  localparam logic [3:0] ST_CLOSE = 4'd3;
  localparam logic [3:0] ST_RD1   = 4'd4;
  localparam logic [3:0] ST_PR1   = 4'd5;
  localparam logic [3:0] ST_HDR   = 4'd6;
  localparam logic [3:0] ST_RD2   = 4'd7;
  localparam logic [3:0] ST_PR2   = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;
  localparam logic [3:0] ST_POST  = 4'd10;

  localparam logic [1:0] SEL_PT = 2'd0;
  localparam logic [1:0] SEL_HI = 2'd1;
  localparam logic [1:0] SEL_LO = 2'd2;

  // Architectural state.
  logic [3:0]                 state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [31:0]                origin_key_r, origin_key_nxt;
  logic [31:0]                origin_pos_r, origin_pos_nxt;
  logic [31:0]                next_pos_r, next_pos_nxt;
  logic [SW-1:0]              upper_r, upper_nxt;
  logic [SW-1:0]              lower_r, lower_nxt;
  logic [31:0]                byte_off_r, byte_off_nxt;
  logic [31:0]                bit_total_r, bit_total_nxt;
  logic [plkc_pkg::EB_W-1:0]  eb_r, eb_nxt;

  // Per-request working registers.
  logic [31:0]                key_r, key_nxt;
  logic                       last_r, last_nxt;
  logic [31:0]                pos_r, pos_nxt;
  logic [31:0]                diff_r, diff_nxt;
  logic [SW-1:0]              hi_r, hi_nxt;
  logic [SW-1:0]              lo_r, lo_nxt;
  logic [1:0]                 sel_r, sel_nxt;
  logic                       start_pend_r, start_pend_nxt;
  logic                       close_final_r, close_final_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [PACC_W-1:0]          pacc_r, pacc_nxt;
  logic signed [63:0]         pred_r, pred_nxt;
  logic [63:0]                maxmag_r, maxmag_nxt;
  logic [SW-1:0]              slope_r, slope_nxt;
  logic [3:0]                 width_r, width_nxt;
  logic [15:0]                acc_r, acc_nxt;
  logic [4:0]                 nacc_r, nacc_nxt;
  logic                       lastkey_r, lastkey_nxt;
  logic                       ov_r, ov_nxt;
  plkc_pkg::out_t             opay_r, opay_nxt;

  plkc_pkg::div_req_t         div_req;
  plkc_pkg::div_rsp_t         div_rsp;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [31:0]                ram_rdata;

  logic [32:0]                in_diff;
  logic                       in_pos;
  logic                       slot_free;
  logic                       cfg_wr;
  logic signed [63:0]         dv;
  logic [63:0]                mag;
  logic                       dv_pos;
  logic [2:0]                 cw;
  logic [3:0]                 width_c;
  logic [8:0]                 code_mask;
  logic [8:0]                 code9;
  logic [AW-1:0]              idx_end;
  logic                       in_cone;

  plkc_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENT)) u_keys (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (key_r),
    .raddr   (idx_r),
    .rdata_r (ram_rdata)
  );

  plkc_div #(.FRAC_BITS(SLOPE_FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // The configuration port never waits; reads return the bound in the low bits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == plkc_pkg::CFG_IDX_EB);
  assign prdata = (paddr[2] == plkc_pkg::CFG_IDX_EB) ? 32'(eb_r) : 32'd0;

  assign in_if.ready = (state_r == ST_IDLE);
  assign slot_free   = !ov_r || out_if.ready;
  assign in_diff     = {1'b0, in_if.key_value} - {1'b0, origin_key_r};
  assign in_pos      = !in_diff[32] && (in_diff[31:0] != 32'd0);
  assign in_cone     = (div_rsp.quo > lower_r) && (upper_r > div_rsp.quo);
  assign idx_end     = AW'(count_r - CNT_W'(1));

  // Delta of the key read from RAM against the registered prediction.
  always_comb begin
    dv     = pred_r - $signed(64'(ram_rdata));
    mag    = dv[63] ? 64'(-dv) : 64'(dv);
    dv_pos = !dv[63] && (dv != 64'sd0);
  end

  // Code width from the largest magnitude: 2 up to 1, else ceil(log2)+2, cap 9.
  always_comb begin
    cw = 3'd0;
    if (maxmag_r > 64'd1) begin
      for (int j = 0; j < 7; j++) begin
        if ((cw == 3'(j)) && ((64'd1 << j) < maxmag_r)) begin
          cw = 3'(j + 1);
        end
      end
    end
    width_c = {1'b0, cw} + 4'd2;
  end

  always_comb begin
    code_mask = (9'd1 << (width_r - 4'd1)) - 9'd1;
    code9     = (9'(mag[7:0]) & code_mask) | (dv_pos ? (9'd1 << (width_r - 4'd1)) : 9'd0);
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    origin_key_nxt  = origin_key_r;
    origin_pos_nxt  = origin_pos_r;
    next_pos_nxt    = next_pos_r;
    upper_nxt       = upper_r;
    lower_nxt       = lower_r;
    byte_off_nxt    = byte_off_r;
    bit_total_nxt   = bit_total_r;
    eb_nxt          = cfg_wr ? pwdata[plkc_pkg::EB_W-1:0] : eb_r;
    key_nxt         = key_r;
    last_nxt        = last_r;
    pos_nxt         = pos_r;
    diff_nxt        = diff_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    sel_nxt         = sel_r;
    start_pend_nxt  = start_pend_r;
    close_final_nxt = close_final_r;
    idx_nxt         = idx_r;
    pacc_nxt        = pacc_r;
    pred_nxt        = pred_r;
    maxmag_nxt      = maxmag_r;
    slope_nxt       = slope_r;
    width_nxt       = width_r;
    acc_nxt         = acc_r;
    nacc_nxt        = nacc_r;
    lastkey_nxt     = lastkey_r;
    ov_nxt          = slot_free ? 1'b0 : ov_r;
    opay_nxt        = opay_r;
    div_req.start   = 1'b0;
    div_req.num     = {1'b0, diff_r};
    div_req.den     = plkc_pkg::DEN_W'(count_r);
    ram_we          = 1'b0;
    ram_waddr       = AW'(count_r);

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          key_nxt      = in_if.key_value;
          last_nxt     = in_if.end_of_keys;
          pos_nxt      = next_pos_r;
          next_pos_nxt = next_pos_r + 32'd1;
          diff_nxt     = in_diff[31:0];
          if (count_r == '0) begin
            // No open segment: the key starts one.
            start_pend_nxt = 1'b1;
            state_nxt      = ST_POST;
          end else if (in_pos) begin
            div_req.start = 1'b1;
            div_req.num   = {1'b0, in_diff[31:0]};
            sel_nxt       = SEL_PT;
            state_nxt     = ST_DIV;
          end else begin
            // Key not above the origin: outside the cone.
            start_pend_nxt  = 1'b1;
            close_final_nxt = !in_if.end_of_keys;
            state_nxt       = ST_CLOSE;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          case (sel_r)
            SEL_PT: begin
              if (in_cone) begin
                div_req.start = 1'b1;
                div_req.num   = {1'b0, diff_r} + 33'(eb_r);
                sel_nxt       = SEL_HI;
              end else begin
                start_pend_nxt  = 1'b1;
                close_final_nxt = !last_r;
                state_nxt       = ST_CLOSE;
              end
            end
            SEL_HI: begin
              hi_nxt = div_rsp.quo;
              if (diff_r > 32'(eb_r)) begin
                div_req.start = 1'b1;
                div_req.num   = {1'b0, diff_r} - 33'(eb_r);
                sel_nxt       = SEL_LO;
              end else begin
                lo_nxt    = '0;
                state_nxt = ST_JOIN;
              end
            end
            default: begin
              lo_nxt    = div_rsp.quo;
              state_nxt = ST_JOIN;
            end
          endcase
        end
      end
      ST_JOIN: begin
        if (upper_r > hi_r) begin
          upper_nxt = hi_r;
        end
        if (lo_r > lower_r) begin
          lower_nxt = lo_r;
        end
        ram_we    = 1'b1;
        ram_waddr = AW'(count_r);
        count_nxt = count_r + CNT_W'(1);
        if (last_r || (count_r + CNT_W'(1) == CNT_W'(MAX_SEGMENT))) begin
          close_final_nxt = 1'b1;
          state_nxt       = ST_CLOSE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        // Midpoint of the cone, or unit slope for a single key.
        slope_nxt  = (count_r > CNT_W'(1)) ?
                     SW'(({1'b0, upper_r} + {1'b0, lower_r}) >> 1) :
                     (SW'(1) << SLOPE_FRACTION_BITS);
        idx_nxt    = '0;
        pacc_nxt   = '0;
        maxmag_nxt = '0;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        pred_nxt  = $signed(64'(origin_key_r) + 64'(pacc_r >> SLOPE_FRACTION_BITS));
        pacc_nxt  = pacc_r + PACC_W'(slope_r);
        state_nxt = ST_PR1;
      end
      ST_PR1: begin
        if (mag > maxmag_r) begin
          maxmag_nxt = mag;
        end
        if (idx_r == idx_end) begin
          state_nxt = ST_HDR;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_RD1;
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          bit_total_nxt = bit_total_r + 32'(10'(width_c) * 10'(count_r)) + plkc_pkg::SEG_COST;
          ov_nxt                       = 1'b1;
          opay_nxt                     = '0;
          opay_nxt.item_kind           = plkc_pkg::KIND_HDR;
          opay_nxt.segment_first_index = origin_pos_r;
          opay_nxt.segment_slope       = slope_r;
          opay_nxt.code_width          = width_c;
          opay_nxt.segment_first_byte  = byte_off_r;
          opay_nxt.running_bits        = bit_total_nxt;
          width_nxt = width_c;
          acc_nxt   = '0;
          nacc_nxt  = '0;
          pacc_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = ST_RD2;
        end
      end
      ST_RD2: begin
        pred_nxt  = $signed(64'(origin_key_r) + 64'(pacc_r >> SLOPE_FRACTION_BITS));
        pacc_nxt  = pacc_r + PACC_W'(slope_r);
        state_nxt = ST_PR2;
      end
      ST_PR2: begin
        acc_nxt     = acc_r | (16'(code9) << nacc_r);
        nacc_nxt    = nacc_r + 5'(width_r);
        lastkey_nxt = (idx_r == idx_end);
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (nacc_r >= 5'd8) begin
          if (slot_free) begin
            ov_nxt               = 1'b1;
            opay_nxt             = '0;
            opay_nxt.item_kind   = plkc_pkg::KIND_BYTE;
            opay_nxt.packed_byte = acc_r[7:0];
            opay_nxt.run_last    = close_final_r && lastkey_r && (nacc_r == 5'd8);
            acc_nxt              = acc_r >> 8;
            nacc_nxt             = nacc_r - 5'd8;
            byte_off_nxt         = byte_off_r + 32'd1;
          end
        end else if (!lastkey_r) begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_RD2;
        end else if (nacc_r != 5'd0) begin
          // Trailing partial byte, zero padded.
          if (slot_free) begin
            ov_nxt               = 1'b1;
            opay_nxt             = '0;
            opay_nxt.item_kind   = plkc_pkg::KIND_BYTE;
            opay_nxt.packed_byte = acc_r[7:0];
            opay_nxt.run_last    = close_final_r;
            nacc_nxt             = '0;
            byte_off_nxt         = byte_off_r + 32'd1;
          end
        end else begin
          count_nxt = '0;
          upper_nxt = plkc_pkg::SLOPE_ONES;
          lower_nxt = '0;
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (start_pend_r) begin
          ram_we         = 1'b1;
          ram_waddr      = '0;
          count_nxt      = CNT_W'(1);
          origin_key_nxt = key_r;
          origin_pos_nxt = pos_r;
          upper_nxt      = plkc_pkg::SLOPE_ONES;
          lower_nxt      = '0;
          start_pend_nxt = 1'b0;
          if (last_r) begin
            close_final_nxt = 1'b1;
            state_nxt       = ST_CLOSE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      origin_key_r  <= '0;
      origin_pos_r  <= '0;
      next_pos_r    <= '0;
      upper_r       <= plkc_pkg::SLOPE_ONES;
      lower_r       <= '0;
      byte_off_r    <= '0;
      bit_total_r   <= '0;
      eb_r          <= plkc_pkg::EB_RESET;
      start_pend_r  <= 1'b0;
      close_final_r <= 1'b0;
      ov_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      origin_key_r  <= origin_key_nxt;
      origin_pos_r  <= origin_pos_nxt;
      next_pos_r    <= next_pos_nxt;
      upper_r       <= upper_nxt;
      lower_r       <= lower_nxt;
      byte_off_r    <= byte_off_nxt;
      bit_total_r   <= bit_total_nxt;
      eb_r          <= eb_nxt;
      start_pend_r  <= start_pend_nxt;
      close_final_r <= close_final_nxt;
      ov_r          <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    last_r    <= last_nxt;
    pos_r     <= pos_nxt;
    diff_r    <= diff_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    sel_r     <= sel_nxt;
    idx_r     <= idx_nxt;
    pacc_r    <= pacc_nxt;
    pred_r    <= pred_nxt;
    maxmag_r  <= maxmag_nxt;
    slope_r   <= slope_nxt;
    width_r   <= width_nxt;
    acc_r     <= acc_nxt;
    nacc_r    <= nacc_nxt;
    lastkey_r <= lastkey_nxt;
    opay_r    <= opay_nxt;
  end

  assign out_if.valid               = ov_r;
  assign out_if.item_kind           = opay_r.item_kind;
  assign out_if.packed_byte         = opay_r.packed_byte;
  assign out_if.segment_first_index = opay_r.segment_first_index;
  assign out_if.segment_slope       = opay_r.segment_slope;
  assign out_if.code_width          = opay_r.code_width;
  assign out_if.segment_first_byte  = opay_r.segment_first_byte;
  assign out_if.running_bits        = opay_r.running_bits;
  assign out_if.run_last            = opay_r.run_last;

`ifndef SYNTHESIS
  // A full buffer always closes before the next key is taken.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (count_r < CNT_W'(MAX_SEGMENT)))
    else $error("segment count reached its limit while idle");

  // The divider answers only while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider result with no division pending");

  // The packing accumulator never holds more than two bytes.
  a_nacc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (nacc_r <= 5'd16))
    else $error("packing accumulator overflow");
`endif

endmodule
`default_nettype wire
